[hw/rtl/framed_command_receiver_top_macros.svh]
// Assertion helpers for the framed command receiver.
// Each check samples on the rising edge of clk and is disabled during reset.
`ifndef FRAMED_COMMAND_RECEIVER_TOP_MACROS_SVH
`define FRAMED_COMMAND_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication
`define FCR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fcr_pkg.sv]
`default_nettype none
package fcr_pkg;

    // Defaults for the top-level parameters
    localparam int DELIM_LEN_DEFAULT   = 2;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Configuration register indexes
    localparam logic [1:0] CFG_START_DELIM  = 2'd0;
    localparam logic [1:0] CFG_END_DELIM    = 2'd1;
    localparam logic [1:0] CFG_PACKAGE_CODE = 2'd2;
    localparam logic [1:0] CFG_PING_INTERVAL = 2'd3;

    // Reset values of the configuration registers
    localparam logic [31:0] PING_INTERVAL_RESET = 32'd1000000;
    localparam logic [7:0]  PACKAGE_CODE_RESET  = 8'd1;

    // Input beat kinds (s_tuser)
    localparam logic IN_BYTE = 1'b0;
    localparam logic IN_TICK = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_CMD  = 3'd2,
        PH_BODY = 3'd3,
        PH_END  = 3'd4,
        PH_PKG  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_PKG  = 2'd1,
        KIND_PING = 2'd2
    } kind_t;

    // One queued operation from front to back
    typedef struct packed {
        logic       is_ping;
        logic [7:0] data;
    } op_t;

    // Result payload, packed lowest field last so that bit 0 is command_code
    typedef struct packed {
        logic        package_done;
        logic [31:0] package_progress;
        logic [31:0] package_offset;
        logic [7:0]  package_byte;
        logic [31:0] body_value;
        logic [7:0]  body_length;
        logic [7:0]  command_code;
    } result_t;

    // Configuration seen by the parser
    typedef struct packed {
        logic [31:0] start_delimiter;
        logic [31:0] end_delimiter;
        logic [7:0]  package_code;
    } parse_cfg_t;

    // Byte pos of a delimiter word
    function automatic logic [7:0] delim_byte(input logic [31:0] word, input logic [1:0] pos);
        logic [7:0] b;
        b = word[{pos, 3'b000} +: 8];
        return b;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/fcr_queue.sv]
`default_nettype none
module fcr_queue #(
    parameter int DEPTH = fcr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire fcr_pkg::op_t              push_op,
    input  wire logic                      pop,
    output fcr_pkg::op_t                   head_op,
    output logic                           empty,
    output logic                           full,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    fcr_pkg::op_t       entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign count   = count_reg;
    assign head_op = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/fcr_front.sv]
`default_nettype none
module fcr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] rx_byte
    input  wire logic          s_tuser,   // [0] cmd
    input  wire logic [31:0]   ping_interval,
    input  wire logic          queue_full,
    output logic               push,
    output fcr_pkg::op_t       push_op
);

    logic [31:0] ping_ticks_reg;
    logic [31:0] ping_ticks_next;
    logic        accept;
    logic        is_tick;
    logic        ping_due;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = (s_tuser == fcr_pkg::IN_TICK);
    assign ping_due = (ping_ticks_reg >= ping_interval);

    // Classify: bytes always go to the queue, ticks only when a ping falls due
    always_comb
    begin
        ping_ticks_next = ping_ticks_reg;
        push            = 1'b0;
        push_op.is_ping = is_tick;
        push_op.data    = s_tdata;
        if (accept)
        begin
            if (is_tick)
            begin
                if (ping_due)
                begin
                    ping_ticks_next = '0;
                    push            = 1'b1;
                end
                else
                begin
                    ping_ticks_next = ping_ticks_reg + 32'd1;
                end
            end
            else
            begin
                push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ping_ticks_reg <= '0;
        end
        else
        begin
            ping_ticks_reg <= ping_ticks_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/fcr_back.sv]
`default_nettype none
module fcr_back #(
    parameter int DELIM_LEN = fcr_pkg::DELIM_LEN_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire fcr_pkg::parse_cfg_t cfg,
    input  wire logic           op_valid,
    input  wire fcr_pkg::op_t   op,
    output logic                pop,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [127:0]        m_tdata,  // command_code, body_length, body_value,
                                          // package_byte, package_offset,
                                          // package_progress, package_done, zero fill
    output logic [1:0]          m_tuser   // [1:0] event_kind
);

    fcr_pkg::phase_t  phase_reg;
    fcr_pkg::phase_t  phase_next;
    logic [1:0]       pos_reg;
    logic [1:0]       pos_next;
    logic [7:0]       frame_length_reg;
    logic [7:0]       frame_length_next;
    logic [7:0]       seen_reg;
    logic [7:0]       seen_next;
    logic [7:0]       frame_command_reg;
    logic [7:0]       frame_command_next;
    logic [31:0]      accum_reg;
    logic [31:0]      accum_next;
    logic [31:0]      pkg_total_reg;
    logic [31:0]      pkg_total_next;
    logic [31:0]      pkg_count_reg;
    logic [31:0]      pkg_count_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    fcr_pkg::kind_t   out_kind_reg;
    fcr_pkg::kind_t   out_kind_next;
    fcr_pkg::result_t out_data_reg;
    fcr_pkg::result_t out_data_next;

    logic             back_ready;
    logic             emit;
    fcr_pkg::kind_t   emit_kind;
    fcr_pkg::result_t emit_data;
    logic [2:0]       pos_inc;
    logic             delim_done;
    logic [7:0]       b;
    logic [31:0]      count_inc;

    assign back_ready = !out_valid_reg || m_tready;
    assign pop        = op_valid && back_ready;
    assign b          = op.data;
    assign pos_inc    = {1'b0, pos_reg} + 3'd1;
    assign delim_done = (pos_inc >= 3'(DELIM_LEN));
    assign count_inc  = pkg_count_reg + 32'd1;

    // Parser next state and event
    always_comb
    begin
        phase_next         = phase_reg;
        pos_next           = pos_reg;
        frame_length_next  = frame_length_reg;
        seen_next          = seen_reg;
        frame_command_next = frame_command_reg;
        accum_next         = accum_reg;
        pkg_total_next     = pkg_total_reg;
        pkg_count_next     = pkg_count_reg;
        emit               = 1'b0;
        emit_kind          = fcr_pkg::KIND_CMD;
        emit_data          = '0;
        if (pop)
        begin
            if (op.is_ping)
            begin
                emit      = 1'b1;
                emit_kind = fcr_pkg::KIND_PING;
            end
            else
            begin
                unique case (phase_reg)
                    fcr_pkg::PH_LEN:
                    begin
                        frame_length_next = b;
                        seen_next         = '0;
                        accum_next        = '0;
                        phase_next        = fcr_pkg::PH_CMD;
                    end
                    fcr_pkg::PH_CMD:
                    begin
                        frame_command_next = b;
                        phase_next = (frame_length_reg == '0) ? fcr_pkg::PH_END
                                                              : fcr_pkg::PH_BODY;
                    end
                    fcr_pkg::PH_BODY:
                    begin
                        // Keep only the first four body bytes, little-endian
                        if (seen_reg[7:2] == '0)
                        begin
                            accum_next[{seen_reg[1:0], 3'b000} +: 8] = b;
                        end
                        seen_next = seen_reg + 8'd1;
                        if (seen_next == frame_length_reg)
                        begin
                            phase_next = fcr_pkg::PH_END;
                        end
                    end
                    fcr_pkg::PH_END:
                    begin
                        if (b != fcr_pkg::delim_byte(cfg.end_delimiter, pos_reg))
                        begin
                            pos_next   = '0;
                            phase_next = fcr_pkg::PH_HUNT;
                        end
                        else if (!delim_done)
                        begin
                            pos_next = pos_inc[1:0];
                        end
                        else
                        begin
                            pos_next               = '0;
                            phase_next             = fcr_pkg::PH_HUNT;
                            emit                   = 1'b1;
                            emit_kind              = fcr_pkg::KIND_CMD;
                            emit_data.command_code = frame_command_reg;
                            emit_data.body_length  = frame_length_reg;
                            emit_data.body_value   = accum_reg;
                            // Open a package transfer on the package command
                            if (frame_command_reg == cfg.package_code)
                            begin
                                pkg_total_next = accum_reg;
                                pkg_count_next = '0;
                                if (accum_reg != '0)
                                begin
                                    phase_next = fcr_pkg::PH_PKG;
                                end
                            end
                        end
                    end
                    fcr_pkg::PH_PKG:
                    begin
                        emit                       = 1'b1;
                        emit_kind                  = fcr_pkg::KIND_PKG;
                        emit_data.package_byte     = b;
                        emit_data.package_offset   = pkg_count_reg;
                        emit_data.package_progress = count_inc;
                        pkg_count_next             = count_inc;
                        if (count_inc >= pkg_total_reg)
                        begin
                            emit_data.package_done = 1'b1;
                            phase_next             = fcr_pkg::PH_HUNT;
                        end
                    end
                    default:
                    begin
                        // Hunt for the start delimiter; a mismatch is not retested
                        phase_next = fcr_pkg::PH_HUNT;
                        if (b == fcr_pkg::delim_byte(cfg.start_delimiter, pos_reg))
                        begin
                            if (delim_done)
                            begin
                                pos_next   = '0;
                                phase_next = fcr_pkg::PH_LEN;
                            end
                            else
                            begin
                                pos_next = pos_inc[1:0];
                            end
                        end
                        else
                        begin
                            pos_next = '0;
                        end
                    end
                endcase
            end
        end
    end

    // Output register: load a new event, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = emit_kind;
            out_data_next  = emit_data;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= fcr_pkg::PH_HUNT;
            pos_reg           <= '0;
            frame_length_reg  <= '0;
            seen_reg          <= '0;
            frame_command_reg <= '0;
            accum_reg         <= '0;
            pkg_total_reg     <= '0;
            pkg_count_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            pos_reg           <= pos_next;
            frame_length_reg  <= frame_length_next;
            seen_reg          <= seen_next;
            frame_command_reg <= frame_command_next;
            accum_reg         <= accum_next;
            pkg_total_reg     <= pkg_total_next;
            pkg_count_reg     <= pkg_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg <= out_kind_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_data_reg};

endmodule
`default_nettype wire

[hw/rtl/framed_command_receiver_top.sv]
`default_nettype none
// Framed command receiver. Input beats carry either a received byte
// (s_tuser = 0, byte in s_tdata[7:0]) or one time tick (s_tuser = 1). Bytes
// are parsed into frames of start delimiter, length, command, body and end
// delimiter; a good frame yields a command event, a package command then
// forwards the following bytes as package events, and every ping_interval
// plus one ticks yield a ping event. One beat is accepted per clock cycle
// while s_tready is high. A front stage classifies beats and counts ticks, a
// queue of QUEUE_DEPTH entries decouples it from the parser, and the parser
// writes each event into a registered output, so a beat passes the queue and
// the output register before m_tvalid rises; s_tready drops only when the
// queue fills while the output is stalled. Configuration writes are taken at
// any edge with cfg_we high and must be issued while the block is idle.
`include "framed_command_receiver_top_macros.svh"
module framed_command_receiver_top #(
    parameter int DELIM_LEN   = fcr_pkg::DELIM_LEN_DEFAULT,
    parameter int QUEUE_DEPTH = fcr_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] rx_byte
    input  wire logic          s_tuser,   // [0] cmd
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [127:0]       m_tdata,   // [7:0] command_code, [15:8] body_length,
                                          // [47:16] body_value, [55:48] package_byte,
                                          // [87:56] package_offset,
                                          // [119:88] package_progress,
                                          // [120] package_done, [127:121] zero
    output logic [1:0]         m_tuser,   // [1:0] event_kind
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_addr,
    input  wire logic [31:0]   cfg_wdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic [31:0]         start_delim_reg;
    logic [31:0]         end_delim_reg;
    logic [7:0]          package_code_reg;
    logic [31:0]         ping_interval_reg;
    fcr_pkg::parse_cfg_t parse_cfg;

    logic                q_push;
    fcr_pkg::op_t        q_push_op;
    logic                q_pop;
    fcr_pkg::op_t        q_head;
    logic                q_empty;
    logic                q_full;
    logic [CNT_W-1:0]    q_count;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_delim_reg   <= '0;
            end_delim_reg     <= '0;
            package_code_reg  <= fcr_pkg::PACKAGE_CODE_RESET;
            ping_interval_reg <= fcr_pkg::PING_INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                fcr_pkg::CFG_START_DELIM:   start_delim_reg   <= cfg_wdata;
                fcr_pkg::CFG_END_DELIM:     end_delim_reg     <= cfg_wdata;
                fcr_pkg::CFG_PACKAGE_CODE:  package_code_reg  <= cfg_wdata[7:0];
                fcr_pkg::CFG_PING_INTERVAL: ping_interval_reg <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    assign parse_cfg.start_delimiter = start_delim_reg;
    assign parse_cfg.end_delimiter   = end_delim_reg;
    assign parse_cfg.package_code    = package_code_reg;

    fcr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .ping_interval (ping_interval_reg),
        .queue_full    (q_full),
        .push          (q_push),
        .push_op       (q_push_op)
    );

    fcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .pop     (q_pop),
        .head_op (q_head),
        .empty   (q_empty),
        .full    (q_full),
        .count   (q_count)
    );

    fcr_back #(
        .DELIM_LEN (DELIM_LEN)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (parse_cfg),
        .op_valid (!q_empty),
        .op       (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Checks
    `FCR_ASSERT_SAME(a_ping_payload_zero, m_tvalid && (m_tuser == fcr_pkg::KIND_PING),
                     m_tdata == '0, "ping event carries payload")
    `FCR_ASSERT_SAME(a_done_only_pkg, m_tvalid && m_tdata[120],
                     m_tuser == fcr_pkg::KIND_PKG, "package_done on non-package event")
    `FCR_ASSERT_NEXT(a_queue_fill, q_push && !q_full && !q_pop,
                     q_count == $past(q_count) + 1'b1, "queue count did not advance on push")

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 100ps

module tb;
    import fcr_pkg::*;

    localparam int DELIM_LEN     = DELIM_LEN_DEFAULT;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int PRINT_LIMIT   = 40;

    // One beat toward the block: a received byte or a time tick
    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
    } rx_beat_t;

    // One event from the block, unpacked from m_tuser / m_tdata
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  code;
        logic [7:0]  blen;
        logic [31:0] bval;
        logic [7:0]  pbyte;
        logic [31:0] poff;
        logic [31:0] pprog;
        logic        pdone;
    } rx_event_t;

    typedef enum {FRAME_GOOD, FRAME_BAD_END, FRAME_CUT} frame_form_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tuser = IN_BYTE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_addr = CFG_START_DELIM;
    logic [31:0]  cfg_wdata = 32'h0;

    // Register copies used by the frame parser below
    logic [31:0] cfg_start = 32'h0;
    logic [31:0] cfg_end = 32'h0;
    logic [7:0]  cfg_pkg_code = PACKAGE_CODE_RESET;
    logic [31:0] cfg_ping = PING_INTERVAL_RESET;

    // Parser and tick counter state
    phase_t      rx_phase = PH_HUNT;
    int          delim_pos = 0;
    logic [7:0]  len_byte = 8'h0;
    logic [7:0]  body_seen = 8'h0;
    logic [7:0]  cmd_byte = 8'h0;
    logic [31:0] body_word = 32'h0;
    logic [31:0] pkg_total = 32'h0;
    logic [31:0] pkg_count = 32'h0;
    logic [31:0] tick_count = 32'h0;

    rx_beat_t  tx_beats [$];
    rx_event_t due_events [$];
    rx_beat_t  next_beat;
    rx_event_t got_event;
    rx_event_t want_event;

    int beats_queued = 0;
    int beats_accepted = 0;
    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int tick_pct = 0;

    framed_command_receiver_top #(
        .DELIM_LEN (DELIM_LEN)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
    endtask

    // Advance the parser and the tick counter by one beat and queue any event it owes
    task automatic parse_beat(input logic is_tick, input logic [7:0] b);
        rx_event_t ev;
        ev = '0;
        if (is_tick == IN_TICK)
        begin
            if (tick_count >= cfg_ping)
            begin
                tick_count = 32'h0;
                ev.kind = KIND_PING;
                due_events.push_back(ev);
            end
            else
                tick_count++;
        end
        else
        begin
            case (rx_phase)
                PH_LEN:
                begin
                    len_byte = b;
                    body_seen = 8'h0;
                    body_word = 32'h0;
                    rx_phase = PH_CMD;
                end
                PH_CMD:
                begin
                    cmd_byte = b;
                    rx_phase = (len_byte == 8'h0) ? PH_END : PH_BODY;
                end
                PH_BODY:
                begin
                    // keep the first four body bytes, little-endian
                    if (body_seen < 8'd4)
                        body_word = body_word | (32'(b) << (8 * body_seen));
                    body_seen++;
                    if (body_seen == len_byte)
                        rx_phase = PH_END;
                end
                PH_END:
                begin
                    if (b != cfg_end[8 * delim_pos +: 8])
                    begin
                        delim_pos = 0;
                        rx_phase = PH_HUNT;
                    end
                    else
                    begin
                        delim_pos++;
                        if (delim_pos >= DELIM_LEN)
                        begin
                            delim_pos = 0;
                            rx_phase = PH_HUNT;
                            ev.kind = KIND_CMD;
                            ev.code = cmd_byte;
                            ev.blen = len_byte;
                            ev.bval = body_word;
                            due_events.push_back(ev);
                            if (cmd_byte == cfg_pkg_code)
                            begin
                                pkg_total = body_word;
                                pkg_count = 32'h0;
                                if (pkg_total != 32'h0)
                                    rx_phase = PH_PKG;
                            end
                        end
                    end
                end
                PH_PKG:
                begin
                    ev.kind = KIND_PKG;
                    ev.pbyte = b;
                    ev.poff = pkg_count;
                    pkg_count++;
                    ev.pprog = pkg_count;
                    if (pkg_count >= pkg_total)
                    begin
                        ev.pdone = 1'b1;
                        rx_phase = PH_HUNT;
                    end
                    due_events.push_back(ev);
                end
                default:
                begin
                    // hunt; a mismatching byte is not tried again at position zero
                    rx_phase = PH_HUNT;
                    if (b == cfg_start[8 * delim_pos +: 8])
                        delim_pos++;
                    else
                        delim_pos = 0;
                    if (delim_pos >= DELIM_LEN)
                    begin
                        delim_pos = 0;
                        rx_phase = PH_LEN;
                    end
                end
            endcase
        end
    endtask

    // Drive the input stream: hold a beat until taken, then load the next or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_beat(s_tuser, s_tdata);
                beats_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_beats.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_beat = tx_beats.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= next_beat.is_tick;
                    s_tdata <= next_beat.data;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Check each event beat against the oldest owed event; stall at random
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_event.kind  = kind_t'(m_tuser);
            got_event.code  = m_tdata[7:0];
            got_event.blen  = m_tdata[15:8];
            got_event.bval  = m_tdata[47:16];
            got_event.pbyte = m_tdata[55:48];
            got_event.poff  = m_tdata[87:56];
            got_event.pprog = m_tdata[119:88];
            got_event.pdone = m_tdata[120];
            if (due_events.size() == 0)
                report_mismatch("unexpected event, kind", 32'(got_event.kind), 32'h0);
            else
            begin
                want_event = due_events.pop_front();
                if (got_event.kind != want_event.kind)
                    report_mismatch("event_kind", 32'(got_event.kind), 32'(want_event.kind));
                if (got_event.code != want_event.code)
                    report_mismatch("command_code", 32'(got_event.code), 32'(want_event.code));
                if (got_event.blen != want_event.blen)
                    report_mismatch("body_length", 32'(got_event.blen), 32'(want_event.blen));
                if (got_event.bval != want_event.bval)
                    report_mismatch("body_value", got_event.bval, want_event.bval);
                if (got_event.pbyte != want_event.pbyte)
                    report_mismatch("package_byte", 32'(got_event.pbyte),
                                    32'(want_event.pbyte));
                if (got_event.poff != want_event.poff)
                    report_mismatch("package_offset", got_event.poff, want_event.poff);
                if (got_event.pprog != want_event.pprog)
                    report_mismatch("package_progress", got_event.pprog, want_event.pprog);
                if (got_event.pdone != want_event.pdone)
                    report_mismatch("package_done", 32'(got_event.pdone),
                                    32'(want_event.pdone));
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Bound the run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_START_DELIM:   cfg_start = value;
            CFG_END_DELIM:     cfg_end = value;
            CFG_PACKAGE_CODE:  cfg_pkg_code = value[7:0];
            CFG_PING_INTERVAL: cfg_ping = value;
            default:           ;
        endcase
    endtask

    // Hold until every beat is taken and answered, then let the pipeline settle
    task automatic wait_drained();
        while (beats_accepted != beats_queued || due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_tick();
        rx_beat_t beat;
        beat.is_tick = IN_TICK;
        beat.data = 8'($urandom);
        tx_beats.push_back(beat);
        beats_queued++;
    endtask

    // Queue a byte, now and then preceded by a tick
    task automatic push_byte(input logic [7:0] b);
        rx_beat_t beat;
        if ($urandom_range(99) < tick_pct)
            push_tick();
        beat.is_tick = IN_BYTE;
        beat.data = b;
        tx_beats.push_back(beat);
        beats_queued++;
    endtask

    // A run of one byte that can neither open a frame nor close one; drains a
    // short leftover body back to hunting
    task automatic push_filler();
        logic [7:0] f;
        do
            f = 8'($urandom);
        while (f == cfg_start[7:0] || f == cfg_end[7:0]);
        repeat (12) push_byte(f);
    endtask

    function automatic logic [7:0] other_code();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == cfg_pkg_code);
        return c;
    endfunction

    task automatic send_frame(input logic [7:0] code, input int len, input logic [31:0] lead,
                              input frame_form_t form);
        int body_sent;
        int bad_pos;
        logic [7:0] b;
        for (int i = 0; i < DELIM_LEN; i++)
            push_byte(cfg_start[8 * i +: 8]);
        push_byte(8'(len));
        push_byte(code);
        body_sent = (form == FRAME_CUT) ? int'($urandom_range(len - 1)) : len;
        for (int i = 0; i < body_sent; i++)
            push_byte((i < 4) ? lead[8 * i +: 8] : 8'($urandom));
        if (form == FRAME_CUT)
            push_filler();
        else
        begin
            // send the end delimiter; for a bad end, corrupt one byte of it and stop there
            bad_pos = (form == FRAME_BAD_END) ? int'($urandom_range(DELIM_LEN - 1)) : DELIM_LEN;
            for (int i = 0; i < DELIM_LEN && i <= bad_pos; i++)
            begin
                b = cfg_end[8 * i +: 8];
                if (i == bad_pos)
                    b = b ^ (8'd1 << $urandom_range(7));
                push_byte(b);
            end
        end
    endtask

    // Package frame with a small total, then exactly that many data bytes
    task automatic send_package();
        int total;
        int len;
        if ($urandom_range(99) < 15)
        begin
            total = 0;
            len = $urandom_range(5);
        end
        else
        begin
            total = $urandom_range(12, 1);
            len = $urandom_range(6, 1);
        end
        send_frame(cfg_pkg_code, len, 32'(total), FRAME_GOOD);
        repeat (total) push_byte(8'($urandom));
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int pick;
        stop_at = beats_queued + count;
        while (beats_queued < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_frame(other_code(), ($urandom_range(99) == 0) ? 255 : $urandom_range(9),
                           $urandom(), FRAME_GOOD);
            else if (pick < 72)
                send_package();
            else if (pick < 80)
                send_frame(other_code(), $urandom_range(6), $urandom(), FRAME_BAD_END);
            else if (pick < 88)
                send_frame(other_code(), $urandom_range(8, 1), $urandom(), FRAME_CUT);
            else if (pick < 93)
            begin
                // start delimiter broken at its second byte
                push_byte(cfg_start[7:0]);
                push_byte(cfg_start[15:8] ^ (8'd1 << $urandom_range(7)));
            end
            else
            begin
                repeat ($urandom_range(6, 1)) push_byte(8'($urandom));
                push_filler();
            end
            // now and then hold the sender until the block has answered everything
            if ($urandom_range(99) < 4)
                wait_drained();
        end
    endtask

    initial
    begin
        logic [7:0] script [$];
        int drain_wait;
        rx_event_t left;

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 21;
        recv_idle_pct = 70;
        tick_pct = 0;

        // Directed: lost sync, empty body, ping, package, empty package
        write_reg(CFG_START_DELIM, 32'h0000A55A);
        write_reg(CFG_END_DELIM, 32'hFFFF0D0A);
        write_reg(CFG_PACKAGE_CODE, 32'hFF);
        write_reg(CFG_PING_INTERVAL, 32'd2);
        script = '{8'h5A, 8'h5A, 8'hA5,
                   8'h5A, 8'hA5, 8'h00, 8'h00, 8'h0A, 8'h0D};
        foreach (script[i])
            push_byte(script[i]);
        repeat (3) push_tick();
        script = '{8'h5A, 8'hA5, 8'h01, 8'hFF, 8'h02, 8'h0A, 8'h0D, 8'hFF, 8'h00,
                   8'h5A, 8'hA5, 8'h00, 8'hFF, 8'h0A, 8'h0D};
        foreach (script[i])
            push_byte(script[i]);

        // Largest interval, then lower it under the tick count
        wait_drained();
        write_reg(CFG_PING_INTERVAL, 32'hFFFFFFFF);
        repeat (4) push_tick();
        wait_drained();
        write_reg(CFG_PING_INTERVAL, 32'd1);
        push_tick();

        // Random, sender mostly busy and receiver mostly stalled
        tick_pct = 6;
        wait_drained();
        write_reg(CFG_START_DELIM, $urandom());
        write_reg(CFG_END_DELIM, $urandom());
        write_reg(CFG_PACKAGE_CODE, 32'h0);
        write_reg(CFG_PING_INTERVAL, 32'd5);
        run_random(370);

        // Random, roles swapped, all-zero and all-one delimiters
        wait_drained();
        send_idle_pct = 70;
        recv_idle_pct = 21;
        write_reg(CFG_START_DELIM, 32'h0);
        write_reg(CFG_END_DELIM, 32'hFFFFFFFF);
        write_reg(CFG_PACKAGE_CODE, 32'(8'($urandom)));
        write_reg(CFG_PING_INTERVAL, 32'd0);
        run_random(370);

        // Random, no idling on either side
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_START_DELIM, $urandom());
        write_reg(CFG_END_DELIM, $urandom());
        write_reg(CFG_PACKAGE_CODE, 32'hFF);
        write_reg(CFG_PING_INTERVAL, $urandom_range(9));
        run_random(370);

        // Wait for the tail, then flag anything still owed
        drain_wait = 0;
        while ((beats_accepted != beats_queued || due_events.size() != 0)
               && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (beats_accepted != beats_queued)
            report_mismatch("beats taken", 32'(beats_accepted), 32'(beats_queued));
        while (due_events.size() != 0)
        begin
            left = due_events.pop_front();
            report_mismatch("missing event, kind", 32'h0, 32'(left.kind));
        end

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
